// ===== hw/rtl/stu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stu_pkg;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OP_TRANS_A = 2'd0,
    OP_TRANS_B = 2'd1,
    OP_RECOMB  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  localparam logic [31:0] PosInf  = 32'h7F80_0000;
  localparam logic [31:0] QNan    = 32'h7FC0_0000;
  localparam logic [31:0] MagMask = 32'h7FFF_FFFF;

  typedef struct packed {
    op_e         op;
    logic [31:0] s0a, s0b, s1a, s1b, s2a, s2b, s3a, s3b;
    logic [31:0] s4a, s4b, s5a, s5b, s6a, s6b;
    logic [6:0]  sub;
    logic [6:0]  pass;
    logic [31:0] r4, r5, r6;
    logic [31:0] peak_a, peak_b;
  } job_t;

  function automatic logic [31:0] peak_upd(input logic [31:0] pk, input logic [31:0] v);
    logic [31:0] m;
    m = v & MagMask;
    if (m >= PosInf) return PosInf;
    if (m > pk) return m;
    return pk;
  endfunction

  // Binary32 add with round to nearest even; NaN results canonical.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b_in,
                                         input logic sub);
    logic [31:0] b, big, sml;
    logic [7:0] ea, eb, e;
    logic [26:0] ma, mb, ms;
    logic [27:0] sum;
    logic [8:0] d;
    logic st, sa, sb, rnd;
    logic [4:0] lz;
    logic [9:0] ex;
    logic [23:0] man;
    logic [24:0] mr;
    int k;
    b = {b_in[31] ^ sub, b_in[30:0]};
    if ((a[30:0] > PosInf[30:0]) || (b[30:0] > PosInf[30:0])) return QNan;
    if (a[30:0] == PosInf[30:0] && b[30:0] == PosInf[30:0])
      return (a[31] == b[31]) ? a : QNan;
    if (a[30:0] == PosInf[30:0]) return a;
    if (b[30:0] == PosInf[30:0]) return b;
    if (a[30:0] >= b[30:0]) begin big = a; sml = b; end else begin big = b; sml = a; end
    sa = big[31]; sb = sml[31];
    ea = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    eb = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    ma = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    mb = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    d = {1'b0, ea} - {1'b0, eb};
    if (d > 9'd26) ms = {26'd0, |mb};
    else begin
      ms = mb >> d[4:0];
      st = |(mb & ~({27{1'b1}} << d[4:0]));
      ms[0] = ms[0] | st;
    end
    if (sa == sb) sum = {1'b0, ma} + {1'b0, ms};
    else sum = {1'b0, ma} - {1'b0, ms};
    if (sum == 28'd0) return {(sa & sb), 31'd0};
    ex = {2'b0, ea};
    if (sum[27]) begin
      sum = {1'b0, sum[27:2], sum[1] | sum[0]};
      ex = ex + 10'd1;
    end else begin
      lz = 5'd0;
      for (k = 26; k >= 0; k--) if (sum[k] && lz == 5'd0 && k != 26) lz = 5'(26 - k);
      if (sum[26]) lz = 5'd0;
      if ({5'd0, lz} >= ex) lz = 5'(ex - 10'd1);
      sum = sum << lz;
      ex = ex - {5'd0, lz};
      if (!sum[26]) ex = 10'd0;
    end
    man = sum[26:3];
    rnd = sum[2] & (sum[1] | sum[0] | man[0]);
    mr = {1'b0, man} + {24'd0, rnd};
    if (mr[24]) begin mr = mr >> 1; ex = ex + 10'd1; end
    else if (ex == 10'd0 && mr[23]) ex = 10'd1;
    if (ex >= 10'd255) return {sa, PosInf[30:0]};
    return {sa, ex[7:0], mr[22:0]};
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/strassen_transform_unit_core.sv =====
`timescale 1ns / 1ps
// Each request is written into the queue, then passes back-end stages one, two and three.
// Throughput: one request per cycle unless back-pressure fills the queue; peaks update on accept.
// The back end runs three add stages with at most one fp adder per lane per stage.
// Reset: asynchronous, active low; peaks return to +0 and the queue empties.
`default_nettype none
module strassen_transform_unit_core import stu_pkg::*; #(
  parameter int unsigned Depth = QDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [1:0]   s_axis_tuser,  // operation
  input  wire logic [223:0] s_axis_tdata,  // x0, x1, x2, x3, x4, x5, x6
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [287:0]      m_axis_tdata   // y0..y6, peak_a, peak_b
);
  job_t fj, qj;
  logic full, empty, pop, acc;

  assign s_axis_tready = !full;
  assign acc = s_axis_tvalid && s_axis_tready;

  stu_front u_front (
    .clk_i, .rst_ni, .en_i(acc), .op_i(s_axis_tuser), .x_i(s_axis_tdata), .job_o(fj)
  );

  stu_queue #(.Depth(Depth)) u_queue (
    .clk_i, .rst_ni, .push_i(acc), .data_i(fj), .full_o(full),
    .pop_i(pop), .data_o(qj), .empty_o(empty)
  );

  logic bk_ready;
  assign pop = bk_ready && !empty;

  stu_back u_back (
    .clk_i, .rst_ni, .in_valid_i(!empty), .job_i(qj), .in_ready_o(bk_ready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .data_o(m_axis_tdata)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !acc) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== hw/rtl/stu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stu_front import stu_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [1:0]   op_i,
  input  wire logic [223:0] x_i,
  output job_t              job_o
);
  logic [31:0] pa_q, pa_d, pb_q, pb_d;
  logic [31:0] x0, x1, x2, x3, x4, x5, x6;
  op_e op;

  assign {x6, x5, x4, x3, x2, x1, x0} = x_i;
  assign op = op_e'(op_i);

  always_comb begin
    pa_d = pa_q;
    pb_d = pb_q;
    job_o = '0;
    job_o.op = op;
    case (op)
      OP_TRANS_A: begin
        pa_d = peak_upd(peak_upd(peak_upd(peak_upd(pa_q, x0), x1), x2), x3);
        job_o.s0a = x0; job_o.s0b = x3; job_o.s1a = x2; job_o.s1b = x3;
        job_o.s2a = x0; job_o.s3a = x3; job_o.pass = 7'b0001100;
        job_o.s4a = x0; job_o.s4b = x1; job_o.s5a = x2; job_o.s5b = x0;
        job_o.s6a = x1; job_o.s6b = x3; job_o.sub = 7'b1100000;
      end
      OP_TRANS_B: begin
        pb_d = peak_upd(peak_upd(peak_upd(peak_upd(pb_q, x0), x1), x2), x3);
        job_o.s0a = x0; job_o.s0b = x3; job_o.s1a = x0;
        job_o.s2a = x1; job_o.s2b = x3; job_o.s3a = x2; job_o.s3b = x0;
        job_o.s4a = x3; job_o.s5a = x0; job_o.s5b = x1; job_o.s6a = x2; job_o.s6b = x3;
        job_o.pass = 7'b0010010; job_o.sub = 7'b0001100;
      end
      OP_RECOMB: begin
        job_o.s0a = x0; job_o.s0b = x3; job_o.s1a = x1; job_o.s1b = x3;
        job_o.s2a = x2; job_o.s2b = x4; job_o.s3a = x0; job_o.s3b = x1;
        job_o.sub = 7'b0001000;
        job_o.r4 = x4; job_o.r5 = x5; job_o.r6 = x6;
      end
      default: begin
        pa_d = '0;
        pb_d = '0;
      end
    endcase
    job_o.peak_a = pa_d;
    job_o.peak_b = pb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q <= '0;
      pb_q <= '0;
    end else if (en_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/stu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stu_queue import stu_pkg::*; #(
  parameter int unsigned Depth = QDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  job_t mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0] cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/stu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stu_back import stu_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  job_t              job_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [287:0]      data_o
);
  // Stage one: the seven first-level adds. Stages two and three: the recombine chains.
  logic        v1_q, v2_q, v3_q, en1, en2, en3;
  op_e         op1_q, op2_q;
  logic [31:0] t_q [7];
  logic [31:0] t_d [7];
  logic [31:0] w_q [7];
  logic [31:0] w_d [7];
  logic [31:0] y_q [7];
  logic [31:0] y_d [7];
  logic [31:0] p3_q, p5_q, p6_q, p7_q, p6b_q, p7b_q;
  logic [31:0] pa1_q, pb1_q, pa2_q, pb2_q, pa3_q, pb3_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;
  assign out_valid_o = v3_q;

  always_comb begin
    t_d[0] = job_i.pass[0] ? job_i.s0a : fp_add(job_i.s0a, job_i.s0b, job_i.sub[0]);
    t_d[1] = job_i.pass[1] ? job_i.s1a : fp_add(job_i.s1a, job_i.s1b, job_i.sub[1]);
    t_d[2] = job_i.pass[2] ? job_i.s2a : fp_add(job_i.s2a, job_i.s2b, job_i.sub[2]);
    t_d[3] = job_i.pass[3] ? job_i.s3a : fp_add(job_i.s3a, job_i.s3b, job_i.sub[3]);
    t_d[4] = job_i.pass[4] ? job_i.s4a : fp_add(job_i.s4a, job_i.s4b, job_i.sub[4]);
    t_d[5] = job_i.pass[5] ? job_i.s5a : fp_add(job_i.s5a, job_i.s5b, job_i.sub[5]);
    t_d[6] = job_i.pass[6] ? job_i.s6a : fp_add(job_i.s6a, job_i.s6b, job_i.sub[6]);
    if (job_i.op == OP_CLEAR || job_i.op == OP_RECOMB) begin
      t_d[4] = '0; t_d[5] = '0; t_d[6] = '0;
    end
    if (job_i.op == OP_CLEAR) begin
      t_d[0] = '0; t_d[1] = '0; t_d[2] = '0; t_d[3] = '0;
    end
  end

  always_comb begin
    w_d = t_q;
    if (op1_q == OP_RECOMB) begin
      w_d[0] = fp_add(t_q[0], p5_q, 1'b1);
      w_d[3] = fp_add(t_q[3], p3_q, 1'b0);
    end
  end

  always_comb begin
    y_d = w_q;
    if (op2_q == OP_RECOMB) begin
      y_d[0] = fp_add(w_q[0], p7b_q, 1'b0);
      y_d[3] = fp_add(w_q[3], p6b_q, 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      t_q <= t_d;
      op1_q <= job_i.op;
      p3_q <= job_i.s2a;
      p5_q <= job_i.r4;
      p6_q <= job_i.r5;
      p7_q <= job_i.r6;
      pa1_q <= job_i.peak_a;
      pb1_q <= job_i.peak_b;
    end
    if (en2 && v1_q) begin
      w_q <= w_d;
      op2_q <= op1_q;
      p6b_q <= p6_q;
      p7b_q <= p7_q;
      pa2_q <= pa1_q;
      pb2_q <= pb1_q;
    end
    if (en3 && v2_q) begin
      y_q <= y_d;
      pa3_q <= pa2_q;
      pb3_q <= pb2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  assign data_o = {pb3_q, pa3_q, y_q[6], y_q[5], y_q[4], y_q[3], y_q[2], y_q[1], y_q[0]};
endmodule
`default_nettype wire

// ===== tb/tb_strassen_transform_unit_core.sv =====
`timescale 1ns / 1ps
module tb_strassen_transform_unit_core;
  import stu_pkg::*;

  typedef logic [8:0][31:0] res_t;
  typedef logic [6:0][31:0] elems_t;

  typedef struct {
    op_e    op;
    elems_t x;
    bit     typed;
    res_t   want;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = 2'd0;  // operation
  logic [223:0] s_axis_tdata = '0;    // x0, x1, x2, x3, x4, x5, x6
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;         // y0..y6, peak_a, peak_b

  logic [31:0] peak_a_q = '0;
  logic [31:0] peak_b_q = '0;
  res_t        result_q[$];
  stim_row_t   stim_tab[$];
  bit          req_typed = 1'b0;
  res_t        req_want = '0;
  int          err_cnt = 0;
  int          req_cnt = 0;
  int          rsp_cnt = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  int          near_exp = 127;

  always #10 clk_i = ~clk_i;

  strassen_transform_unit_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [31:0] f32_sum(logic [31:0] a, logic [31:0] b_in, bit neg);
    logic [31:0] b, hi, lo;
    int ehi, elo, d, p, e, sh;
    longint unsigned mhi, mlo, r, m, rem, half;
    bit rnd, stk;
    b = {b_in[31] ^ neg, b_in[30:0]};
    if (a[30:0] > PosInf[30:0] || b[30:0] > PosInf[30:0]) return QNan;
    if (a[30:0] == PosInf[30:0] && b[30:0] == PosInf[30:0])
      return (a[31] == b[31]) ? a : QNan;
    if (a[30:0] == PosInf[30:0]) return a;
    if (b[30:0] == PosInf[30:0]) return b;
    if (a[30:0] >= b[30:0]) begin
      hi = a; lo = b;
    end else begin
      hi = b; lo = a;
    end
    ehi = (hi[30:23] == 8'd0) ? 1 : int'(hi[30:23]);
    elo = (lo[30:23] == 8'd0) ? 1 : int'(lo[30:23]);
    mhi = longint'({hi[30:23] != 8'd0, hi[22:0]}) << 30;
    mlo = longint'({lo[30:23] != 8'd0, lo[22:0]}) << 30;
    d = ehi - elo;
    if (d > 60) begin
      mlo = (mlo != 0) ? 64'd1 : 64'd0;
    end else begin
      stk = (mlo & ((64'd1 << d) - 64'd1)) != 0;
      mlo = (mlo >> d) | longint'(stk);
    end
    r = (hi[31] == lo[31]) ? mhi + mlo : mhi - mlo;
    if (r == 0) return {hi[31] & lo[31], 31'd0};
    p = 63;
    while (!r[p]) p--;
    e = p + ehi - 53;
    if (e < 1) e = 1;
    sh = e - ehi + 30;
    rnd = 1'b0;
    if (sh <= 0) begin
      m = r << (-sh);
    end else begin
      m = r >> sh;
      rem = r & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      rnd = (rem > half) || (rem == half && m[0]);
    end
    m = m + longint'(rnd);
    if (m >= (64'd1 << 24)) begin
      m = m >> 1;
      e++;
    end
    if (e >= 255) return {hi[31], PosInf[30:0]};
    return {hi[31], m[23] ? 8'(e) : 8'd0, m[22:0]};
  endfunction

  function automatic logic [31:0] peak_next(logic [31:0] pk, logic [31:0] v);
    if ((v & MagMask) >= PosInf) return PosInf;
    if ((v & MagMask) > pk) return v & MagMask;
    return pk;
  endfunction

  function automatic res_t strassen_step(op_e op, elems_t x);
    res_t y;
    y = '0;
    case (op)
      OP_TRANS_A: begin
        for (int i = 0; i < 4; i++) peak_a_q = peak_next(peak_a_q, x[i]);
        y[0] = f32_sum(x[0], x[3], 1'b0);
        y[1] = f32_sum(x[2], x[3], 1'b0);
        y[2] = x[0];
        y[3] = x[3];
        y[4] = f32_sum(x[0], x[1], 1'b0);
        y[5] = f32_sum(x[2], x[0], 1'b1);
        y[6] = f32_sum(x[1], x[3], 1'b1);
      end
      OP_TRANS_B: begin
        for (int i = 0; i < 4; i++) peak_b_q = peak_next(peak_b_q, x[i]);
        y[0] = f32_sum(x[0], x[3], 1'b0);
        y[1] = x[0];
        y[2] = f32_sum(x[1], x[3], 1'b1);
        y[3] = f32_sum(x[2], x[0], 1'b1);
        y[4] = x[3];
        y[5] = f32_sum(x[0], x[1], 1'b0);
        y[6] = f32_sum(x[2], x[3], 1'b0);
      end
      OP_RECOMB: begin
        y[0] = f32_sum(f32_sum(f32_sum(x[0], x[3], 1'b0), x[4], 1'b1), x[6], 1'b0);
        y[1] = f32_sum(x[1], x[3], 1'b0);
        y[2] = f32_sum(x[2], x[4], 1'b0);
        y[3] = f32_sum(f32_sum(f32_sum(x[0], x[1], 1'b1), x[2], 1'b0), x[5], 1'b0);
      end
      default: begin
        peak_a_q = '0;
        peak_b_q = '0;
      end
    endcase
    y[7] = peak_a_q;
    y[8] = peak_b_q;
    return y;
  endfunction

  task automatic report_mismatch(int field, logic [31:0] got, logic [31:0] want);
    $display("result %0d field %0d: got %08h, expected %08h", rsp_cnt, field, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    res_t pred, want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pred = strassen_step(op_e'(s_axis_tuser), elems_t'(s_axis_tdata));
      result_q.push_back(req_typed ? req_want : pred);
      req_cnt++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("result %0d arrived with nothing outstanding", rsp_cnt);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        for (int f = 0; f < 9; f++)
          if (m_axis_tdata[32*f +: 32] !== want[f])
            report_mismatch(f, m_axis_tdata[32*f +: 32], want[f]);
      end
      rsp_cnt++;
    end
  end

  // The receiver stalls for a long stretch once, so the block fills up.
  always @(posedge clk_i) begin
    if (!hold_done && req_cnt >= 300) begin
      hold_done <= 1'b1;
      hold_cnt <= 90;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  function automatic logic [31:0] rand_fp();
    case ($urandom_range(9))
      0: case ($urandom_range(7))
        0: return 32'h0000_0000;
        1: return 32'h8000_0000;
        2: return {1'($urandom_range(1)), PosInf[30:0]};
        3: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
        4: return {1'($urandom_range(1)), 31'h7F7F_FFFF};
        5: return {1'($urandom_range(1)), 31'h0080_0000};
        6: return {1'($urandom_range(1)), 31'h0000_0001};
        default: return {1'($urandom_range(1)), 31'h3F80_0000};
      endcase
      1: return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
      2, 3, 4, 5: return {1'($urandom_range(1)), 8'(near_exp + $urandom_range(2) - 1),
                          23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(op_e op, elems_t x, bit typed, res_t want);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= x;
    req_typed <= typed;
    req_want <= want;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  function automatic void add_row(op_e op, elems_t x, bit typed, res_t want);
    stim_row_t row;
    row.op = op;
    row.x = x;
    row.typed = typed;
    row.want = want;
    stim_tab.push_back(row);
  endfunction

  initial begin
    elems_t x;
    op_e op;
    int pick;
    add_row(OP_CLEAR, '0, 1'b1, '0);
    add_row(OP_TRANS_A, '0, 1'b1, '0);
    add_row(OP_TRANS_A, {96'd0, 32'h7F80_0000}, 1'b1,
            {32'd0, PosInf, 32'd0, 32'hFF80_0000, PosInf, 32'd0, PosInf, 32'd0, PosInf});
    add_row(OP_CLEAR, {7{32'hFFFF_FFFF}}, 1'b1, '0);
    add_row(OP_TRANS_B, '0, 1'b1, '0);
    add_row(OP_TRANS_A, {7{32'h7F7F_FFFF}}, 1'b0, '0);
    add_row(OP_TRANS_A, {7{32'hFF7F_FFFF}}, 1'b0, '0);
    add_row(OP_TRANS_A, {96'd0, 32'h007F_FFFF, 32'h8000_0003, 32'h0000_0002, 32'h0000_0001},
            1'b0, '0);
    add_row(OP_TRANS_B, {96'd0, 32'h3F80_0000, 32'hFFC0_1234, 32'h4000_0000, 32'h7FA0_0001},
            1'b0, '0);
    add_row(OP_TRANS_B, {96'd0, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000},
            1'b0, '0);
    add_row(OP_CLEAR, '0, 1'b1, '0);
    add_row(OP_RECOMB, '0, 1'b1, '0);
    add_row(OP_RECOMB, {32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000, 32'h7F80_0000,
                        32'h4000_0000, 32'h7F80_0000, 32'hFF80_0000}, 1'b0, '0);
    add_row(OP_TRANS_A, {96'd0, 32'h8080_0000, 32'h0080_0001, 32'h0080_0000, 32'h0080_0001},
            1'b0, '0);
    add_row(OP_TRANS_A, {96'd0, 32'hB380_0000, 32'h3380_0000, 32'h3380_0000, 32'h3F80_0000},
            1'b0, '0);
    add_row(OP_TRANS_B, {32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFFF, 32'h4B00_0001,
                         32'hCB00_0000, 32'h3F7F_FFFF, 32'h3380_0001}, 1'b0, '0);
    add_row(OP_RECOMB, {32'h3F80_0000, 32'h3F80_0001, 32'hB380_0000, 32'h7F7F_FFFF,
                        32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0001}, 1'b0, '0);
    add_row(OP_CLEAR, '0, 1'b1, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle = 14;
    rcv_idle = 48;
    foreach (stim_tab[i])
      send_req(stim_tab[i].op, stim_tab[i].x, stim_tab[i].typed, stim_tab[i].want);
    for (int n = 0; n < 1830; n++) begin
      if (n == 610) begin
        snd_idle = 48;
        rcv_idle = 14;
      end else if (n == 1220) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (n == 900) begin
        s_axis_tvalid <= 1'b0;
        wait (result_q.size() == 0);
        @(posedge clk_i);
      end
      near_exp = $urandom_range(2, 253);
      pick = $urandom_range(99);
      op = (pick < 4) ? OP_CLEAR : op_e'(pick % 3);
      for (int i = 0; i < 7; i++) x[i] = rand_fp();
      send_req(op, x, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d transform, recombine and clear requests with special values,",
             req_cnt);
    $display("checked %0d results under sender and receiver stalls.", rsp_cnt);
    if (err_cnt == 0) begin
      $display("tb_strassen_transform_unit_core: done, clean");
    end else begin
      $display("tb_strassen_transform_unit_core: done, errors");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Timeout with %0d results outstanding.", result_q.size());
    $display("tb_strassen_transform_unit_core: done, errors");
    $finish;
  end
endmodule

// ===== strassen_transform_unit_core.f =====
hw/rtl/stu_pkg.sv
hw/rtl/stu_front.sv
hw/rtl/stu_queue.sv
hw/rtl/stu_back.sv
hw/rtl/strassen_transform_unit_core.sv
tb/tb_strassen_transform_unit_core.sv
